// File: hw/rtl/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the sparse polynomial merge adder.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int COEF_W = 16;
    localparam int EXP_W  = 8;
    localparam int SUM_W  = COEF_W + 1;
    localparam int OP_W   = 2;

    // op codes carried in the input tuser
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_MERGE  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic exhausted;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/spm_ctrl.sv
// ----------------------------------------------------------------------------
// spm_ctrl
// Controller: accepts words while idle, sequences the merge walk.
// ----------------------------------------------------------------------------
module spm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [spm_pkg::OP_W-1:0]  i_op,
    output logic                      o_ready,
    input  spm_pkg::t_status          i_status,
    output spm_pkg::t_cmd             o_cmd
);

    spm_pkg::t_state r_state;
    spm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spm_pkg::ST_IDLE: begin
                if (i_valid && i_op == spm_pkg::OP_MERGE) begin
                    n_state = spm_pkg::ST_MERGE;
                end
            end
            spm_pkg::ST_MERGE: begin
                if (i_status.exhausted) begin
                    n_state = spm_pkg::ST_IDLE;
                end
            end
            default: n_state = spm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            spm_pkg::ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.load_a = i_valid && i_op == spm_pkg::OP_LOAD_A;
                o_cmd.load_b = i_valid && i_op == spm_pkg::OP_LOAD_B;
            end
            spm_pkg::ST_MERGE: begin
                // clear the lists once both heads ran off the end
                o_cmd.finish = i_status.exhausted;
                o_cmd.step   = !i_status.exhausted && i_status.out_free;
            end
            default: o_ready = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/spm_dp.sv
// ----------------------------------------------------------------------------
// spm_dp
// Datapath: two term lists, head pointers, compare and add, output register.
// ----------------------------------------------------------------------------
module spm_dp #(
    parameter int MAX_TERMS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  spm_pkg::t_cmd                  i_cmd,
    output spm_pkg::t_status               o_status,
    input  logic signed [spm_pkg::COEF_W-1:0] i_coef,
    input  logic [spm_pkg::EXP_W-1:0]      i_exp,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic signed [spm_pkg::SUM_W-1:0] o_sum_coef,
    output logic [spm_pkg::EXP_W-1:0]      o_sum_exp,
    output logic                           o_last,
    output logic                           o_dropped
);

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    logic signed [spm_pkg::COEF_W-1:0] r_a_coef [MAX_TERMS];
    logic [spm_pkg::EXP_W-1:0]         r_a_exp  [MAX_TERMS];
    logic signed [spm_pkg::COEF_W-1:0] r_b_coef [MAX_TERMS];
    logic [spm_pkg::EXP_W-1:0]         r_b_exp  [MAX_TERMS];

    logic [CW-1:0] r_cnt_a, r_cnt_b, r_ptr_a, r_ptr_b;
    logic [CW-1:0] n_ptr_a, n_ptr_b;
    logic          r_ovf;
    logic          r_ovalid;
    logic signed [spm_pkg::SUM_W-1:0] r_sum_coef;
    logic [spm_pkg::EXP_W-1:0]        r_sum_exp;
    logic                             r_last;
    logic                             r_dropped;

    logic a_has, b_has, take_a, take_b;
    logic signed [spm_pkg::COEF_W-1:0] a_coef, b_coef;
    logic [spm_pkg::EXP_W-1:0]         a_exp, b_exp;
    logic signed [spm_pkg::SUM_W-1:0]  n_sum_coef;
    logic [spm_pkg::EXP_W-1:0]         n_sum_exp;
    logic                              n_last;

    assign a_has  = r_ptr_a < r_cnt_a;
    assign b_has  = r_ptr_b < r_cnt_b;
    assign a_coef = r_a_coef[r_ptr_a[IW-1:0]];
    assign a_exp  = r_a_exp[r_ptr_a[IW-1:0]];
    assign b_coef = r_b_coef[r_ptr_b[IW-1:0]];
    assign b_exp  = r_b_exp[r_ptr_b[IW-1:0]];

    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        if (a_has && b_has) begin
            take_a = a_exp >= b_exp;
            take_b = b_exp >= a_exp;
        end else begin
            take_a = a_has;
            take_b = b_has;
        end
        if (take_a && take_b) begin
            n_sum_coef = spm_pkg::SUM_W'(a_coef) + spm_pkg::SUM_W'(b_coef);
        end else if (take_a) begin
            n_sum_coef = spm_pkg::SUM_W'(a_coef);
        end else begin
            n_sum_coef = spm_pkg::SUM_W'(b_coef);
        end
        n_sum_exp = take_a ? a_exp : b_exp;
        n_ptr_a   = r_ptr_a + CW'(take_a);
        n_ptr_b   = r_ptr_b + CW'(take_b);
        n_last    = !(n_ptr_a < r_cnt_a) && !(n_ptr_b < r_cnt_b);
    end

    assign o_status.exhausted = !a_has && !b_has;
    assign o_status.out_free  = !r_ovalid || i_out_ready;

    // list storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && r_cnt_a < CW'(MAX_TERMS)) begin
            r_a_coef[r_cnt_a[IW-1:0]] <= i_coef;
            r_a_exp[r_cnt_a[IW-1:0]]  <= i_exp;
        end
        if (i_cmd.load_b && r_cnt_b < CW'(MAX_TERMS)) begin
            r_b_coef[r_cnt_b[IW-1:0]] <= i_coef;
            r_b_exp[r_cnt_b[IW-1:0]]  <= i_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_ptr_a  <= '0;
            r_ptr_b  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load_a) begin
                if (r_cnt_a < CW'(MAX_TERMS)) begin
                    r_cnt_a <= r_cnt_a + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.load_b) begin
                if (r_cnt_b < CW'(MAX_TERMS)) begin
                    r_cnt_b <= r_cnt_b + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.step) begin
                r_ptr_a <= n_ptr_a;
                r_ptr_b <= n_ptr_b;
            end
            if (i_cmd.finish) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
                r_ptr_a <= '0;
                r_ptr_b <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.step) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_sum_coef <= n_sum_coef;
            r_sum_exp  <= n_sum_exp;
            r_last     <= n_last;
            r_dropped  <= r_ovf;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_sum_coef  = r_sum_coef;
    assign o_sum_exp   = r_sum_exp;
    assign o_last      = r_last;
    assign o_dropped   = r_dropped;

endmodule

// File: hw/rtl/sparse_polynomial_add_merge.sv
// A load word is written into its list at the clock edge that accepts it. A merge
// word moves the controller to ST_MERGE, which registers the merged words.
// throughput: loads one per cycle while idle; a merge holds the input until both
// lists run out, with one word per cycle out of the head compare and add unit
// while the output is not stalled
// reset: synchronous active-low clears counts, pointers, drop flag and state
// ----------------------------------------------------------------------------
// sparse_polynomial_add_merge
// Adds two sparse polynomials held as descending-exponent term lists.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_merge #(
    parameter int MAX_TERMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // coefficient[15:0], exponent[23:16]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sum_coefficient[16:0], sum_exponent[24:17]
    output logic        m_axis_tlast,   // last_term
    output logic        m_axis_tuser    // load_dropped
);

    spm_pkg::t_cmd    cmd;
    spm_pkg::t_status status;

    logic signed [spm_pkg::SUM_W-1:0] sum_coef;
    logic [spm_pkg::EXP_W-1:0]        sum_exp;

    spm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_op     (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    spm_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_coef      (s_axis_tdata[15:0]),
        .i_exp       (s_axis_tdata[23:16]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_sum_coef  (sum_coef),
        .o_sum_exp   (sum_exp),
        .o_last      (m_axis_tlast),
        .o_dropped   (m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, sum_exp, sum_coef};

endmodule

// File: hw/rtl/spm_checker.sv
// ----------------------------------------------------------------------------
// spm_assert
// Port-level checks for the sparse polynomial merge adder.
// ----------------------------------------------------------------------------
module spm_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped before taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    // a merge still in flight blocks the input
    a_busy_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready while merge words remain");

    // drop flag is the same on every word of one merge
    a_drop_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || m_axis_tuser == $past(m_axis_tuser))
        else $error("drop flag changed inside a merge");

endmodule

bind sparse_polynomial_add_merge spm_assert u_spm_assert (.*);

// File: bench/spm_checker.sv
// ----------------------------------------------------------------------------
// spm_checker
// Watches both stream channels of the sparse polynomial merge adder. It keeps
// its own copy of the two term lists, works out the merged terms for every
// merge word and compares each output word against the oldest pending term.
// ----------------------------------------------------------------------------
module spm_checker #(
    parameter int MAX_TERMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // coefficient[15:0], exponent[23:16]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // sum_coefficient[16:0], sum_exponent[24:17]
    input  logic        m_axis_tlast,   // last_term
    input  logic        m_axis_tuser,   // load_dropped
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_out,
    output int          o_merges,
    output int          o_drop_merges
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [spm_pkg::COEF_W-1:0] coef;
        logic [spm_pkg::EXP_W-1:0]         expo;
    } t_term;

    typedef struct {
        logic signed [spm_pkg::SUM_W-1:0] coef;
        logic [spm_pkg::EXP_W-1:0]        expo;
        logic                             last;
        logic                             dropped;
    } t_sum_term;

    t_term     list_a [MAX_TERMS];
    t_term     list_b [MAX_TERMS];
    int        count_a;
    int        count_b;
    logic      drop_seen;
    t_sum_term sum_q [$];
    int        fails;
    int        words_out;
    int        merges;
    int        drop_merges;

    initial begin
        count_a     = 0;
        count_b     = 0;
        drop_seen   = 1'b0;
        fails       = 0;
        words_out   = 0;
        merges      = 0;
        drop_merges = 0;
    end

    task automatic store_term(input bit to_b, input t_term t);
        if (!to_b) begin
            if (count_a >= MAX_TERMS) begin
                drop_seen = 1'b1;
            end else begin
                list_a[count_a] = t;
                count_a++;
            end
        end else begin
            if (count_b >= MAX_TERMS) begin
                drop_seen = 1'b1;
            end else begin
                list_b[count_b] = t;
                count_b++;
            end
        end
    endtask

    task automatic push_sum(input logic signed [spm_pkg::SUM_W-1:0] c,
                            input logic [spm_pkg::EXP_W-1:0] e);
        t_sum_term t;
        t.coef    = c;
        t.expo    = e;
        t.last    = 1'b0;
        t.dropped = drop_seen;
        sum_q.push_back(t);
    endtask

    task automatic merge_lists();
        int ia;
        int ib;
        int start;
        logic signed [spm_pkg::SUM_W-1:0] s;
        ia    = 0;
        ib    = 0;
        start = sum_q.size();
        while (ia < count_a && ib < count_b) begin
            if (list_a[ia].expo == list_b[ib].expo) begin
                s = $signed(list_a[ia].coef) + $signed(list_b[ib].coef);
                push_sum(s, list_a[ia].expo);
                ia++;
                ib++;
            end else if (list_a[ia].expo > list_b[ib].expo) begin
                s = $signed(list_a[ia].coef);
                push_sum(s, list_a[ia].expo);
                ia++;
            end else begin
                s = $signed(list_b[ib].coef);
                push_sum(s, list_b[ib].expo);
                ib++;
            end
        end
        // remaining tail of whichever list is left
        while (ia < count_a) begin
            s = $signed(list_a[ia].coef);
            push_sum(s, list_a[ia].expo);
            ia++;
        end
        while (ib < count_b) begin
            s = $signed(list_b[ib].coef);
            push_sum(s, list_b[ib].expo);
            ib++;
        end
        merges++;
        if (sum_q.size() > start) begin
            sum_q[sum_q.size()-1].last = 1'b1;
            if (drop_seen)
                drop_merges++;
        end
        count_a   = 0;
        count_b   = 0;
        drop_seen = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_sum_term                        want;
        t_term                            t;
        logic signed [spm_pkg::SUM_W-1:0] got_coef;
        logic [spm_pkg::EXP_W-1:0]        got_expo;
        if (!i_rst_n) begin
            count_a   = 0;
            count_b   = 0;
            drop_seen = 1'b0;
            sum_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                t.coef = s_axis_tdata[15:0];
                t.expo = s_axis_tdata[23:16];
                case (s_axis_tuser)
                    spm_pkg::OP_LOAD_A: store_term(1'b0, t);
                    spm_pkg::OP_LOAD_B: store_term(1'b1, t);
                    spm_pkg::OP_MERGE:  merge_lists();
                    default:            ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                words_out++;
                got_coef = m_axis_tdata[16:0];
                got_expo = m_axis_tdata[24:17];
                if (sum_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected word: coef %0d exp %0d last %0b drop %0b",
                                 got_coef, got_expo, m_axis_tlast, m_axis_tuser);
                end else begin
                    want = sum_q.pop_front();
                    if (got_coef !== want.coef || got_expo !== want.expo ||
                        m_axis_tlast !== want.last || m_axis_tuser !== want.dropped) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: expected coef %0d exp %0d last %0b drop %0b",
                                     want.coef, want.expo, want.last, want.dropped);
                            $display("          got      coef %0d exp %0d last %0b drop %0b",
                                     got_coef, got_expo, m_axis_tlast, m_axis_tuser);
                        end
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_pending     <= sum_q.size();
        o_words_out   <= words_out;
        o_merges      <= merges;
        o_drop_merges <= drop_merges;
    end

endmodule

// File: bench/tb_sparse_polynomial_add_merge.sv
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_add_merge
// Drives load and merge words into the adder with random gaps and output
// stalls; a checker beside the block predicts and compares every merged term.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_add_merge;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TERMS   = 16;
    localparam int ITEM_TARGET = 260;
    localparam int QUIET_TAIL  = 40;
    localparam int LIMIT       = 300000;

    // op code the block must ignore
    localparam logic [spm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // coefficient[15:0], exponent[23:16]
    logic [1:0]  s_axis_tuser  = '0;    // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // sum_coefficient[16:0], sum_exponent[24:17]
    logic        m_axis_tlast;          // last_term
    logic        m_axis_tuser;          // load_dropped

    int chk_fail;
    int chk_pending;
    int chk_words_out;
    int chk_merges;
    int chk_drop_merges;

    int words_sent   = 0;
    int cycle_count  = 0;
    int stall_left   = 0;
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;

    sparse_polynomial_add_merge #(
        .MAX_TERMS (MAX_TERMS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    spm_checker #(
        .MAX_TERMS (MAX_TERMS)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (chk_fail),
        .o_pending     (chk_pending),
        .o_words_out   (chk_words_out),
        .o_merges      (chk_merges),
        .o_drop_merges (chk_drop_merges)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // output side: random stall bursts while sink stalls are enabled
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", LIMIT);
        $display("tb_sparse_polynomial_add_merge NOT OK");
        $finish;
    end

    task automatic put_word(input logic [spm_pkg::OP_W-1:0] op,
                            input logic [spm_pkg::COEF_W-1:0] coef,
                            input logic [spm_pkg::EXP_W-1:0] expo);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {expo, coef};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (op != OP_UNUSED)
            words_sent++;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    function automatic logic [spm_pkg::COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return spm_pkg::COEF_W'($urandom);
        endcase
    endfunction

    function automatic int step_down(input int cur);
        int step;
        step = $urandom_range(1, 3);
        return (cur > step) ? cur - step : 0;
    endfunction

    // one load burst into both lists in random interleave, then one or two merges
    task automatic run_sequence(input int na, input int nb, input bit ordered);
        int ia;
        int ib;
        int cur_a;
        int cur_b;
        int e;
        bit pick_b;
        ia    = 0;
        ib    = 0;
        cur_a = $urandom_range(0, 255);
        cur_b = (cur_a > 2) ? cur_a - $urandom_range(0, 2) : cur_a;
        while (ia < na || ib < nb) begin
            if ($urandom_range(0, 11) == 0)
                put_word(OP_UNUSED, spm_pkg::COEF_W'($urandom), spm_pkg::EXP_W'($urandom));
            pick_b = (ia >= na) || (ib < nb && $urandom_range(0, 1) == 1);
            if (pick_b) begin
                e = ordered ? cur_b : $urandom_range(0, 255);
                put_word(spm_pkg::OP_LOAD_B, rand_coef(), spm_pkg::EXP_W'(e));
                cur_b = step_down(cur_b);
                ib++;
            end else begin
                e = ordered ? cur_a : $urandom_range(0, 255);
                put_word(spm_pkg::OP_LOAD_A, rand_coef(), spm_pkg::EXP_W'(e));
                cur_a = step_down(cur_a);
                ia++;
            end
        end
        put_word(spm_pkg::OP_MERGE, spm_pkg::COEF_W'($urandom), spm_pkg::EXP_W'($urandom));
        // back-to-back merge hits the empty-list case
        if ($urandom_range(0, 9) == 0)
            put_word(spm_pkg::OP_MERGE, spm_pkg::COEF_W'($urandom),
                     spm_pkg::EXP_W'($urandom));
    endtask

    initial begin
        int  seq;
        int  na;
        int  nb;
        bit  quiet;
        seq = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // merge with nothing loaded, then an ignored op
        put_word(spm_pkg::OP_MERGE, 16'h1234, 8'h56);
        put_word(OP_UNUSED, 16'hFFFF, 8'hFF);

        // equal exponents at the coefficient extremes, and a zero sum
        put_word(spm_pkg::OP_LOAD_A, 16'h7FFF, 8'd255);
        put_word(spm_pkg::OP_LOAD_B, 16'h7FFF, 8'd255);
        put_word(spm_pkg::OP_LOAD_A, 16'h8000, 8'd128);
        put_word(spm_pkg::OP_LOAD_B, 16'h8000, 8'd128);
        put_word(spm_pkg::OP_LOAD_B, 16'h0001, 8'd7);
        put_word(spm_pkg::OP_LOAD_A, 16'h0005, 8'd0);
        put_word(spm_pkg::OP_LOAD_B, 16'hFFFB, 8'd0);
        put_word(spm_pkg::OP_MERGE, 16'h0000, 8'h00);

        // only one list holds terms
        put_word(spm_pkg::OP_LOAD_A, 16'd100, 8'd200);
        put_word(spm_pkg::OP_LOAD_A, 16'hFFFF, 8'd3);
        put_word(spm_pkg::OP_MERGE, 16'hFFFF, 8'hFF);
        put_word(spm_pkg::OP_LOAD_B, 16'h5555, 8'hAA);
        put_word(spm_pkg::OP_MERGE, 16'hAAAA, 8'h55);

        // first list entirely above the second
        put_word(spm_pkg::OP_LOAD_A, 16'd1, 8'd250);
        put_word(spm_pkg::OP_LOAD_A, 16'd2, 8'd240);
        put_word(spm_pkg::OP_LOAD_B, 16'd3, 8'd10);
        put_word(spm_pkg::OP_MERGE, 16'h0000, 8'h00);

        // terms out of order are merged as they stand
        put_word(spm_pkg::OP_LOAD_A, 16'd1, 8'd5);
        put_word(spm_pkg::OP_LOAD_A, 16'd2, 8'd9);
        put_word(spm_pkg::OP_LOAD_B, 16'd3, 8'd7);
        put_word(spm_pkg::OP_MERGE, 16'h0000, 8'h00);

        while (words_sent < ITEM_TARGET) begin
            quiet        = (words_sent >= ITEM_TARGET - QUIET_TAIL);
            src_idle_on  = !quiet && ($urandom_range(0, 3) != 0);
            sink_idle_on <= !quiet && ($urandom_range(0, 3) != 0);
            if (seq == 0) begin
                // overflow of the first list
                na = MAX_TERMS + 1;
                nb = $urandom_range(0, 3);
            end else if (seq == 1) begin
                na = $urandom_range(0, 3);
                nb = MAX_TERMS + 2;
            end else begin
                na = ($urandom_range(0, 9) == 0) ? $urandom_range(6, MAX_TERMS + 2)
                                                 : $urandom_range(0, 5);
                nb = ($urandom_range(0, 9) == 0) ? $urandom_range(6, MAX_TERMS + 2)
                                                 : $urandom_range(0, 5);
            end
            run_sequence(na, nb, $urandom_range(0, 9) != 0);
            seq++;
        end
        s_axis_tvalid <= 1'b0;

        // let the checker's pending count take in the last accepted word
        @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d load and merge words in %0d sequences, %0d merges, %0d terms out",
                 words_sent, seq, chk_merges, chk_words_out);
        $display("%0d merges flagged dropped loads", chk_drop_merges);
        if (chk_fail == 0)
            $display("tb_sparse_polynomial_add_merge OK");
        else
            $display("tb_sparse_polynomial_add_merge NOT OK");
        $finish;
    end

endmodule

// File: sparse_polynomial_add_merge.f
hw/rtl/spm_pkg.sv
hw/rtl/spm_ctrl.sv
hw/rtl/spm_dp.sv
hw/rtl/sparse_polynomial_add_merge.sv
hw/rtl/spm_checker.sv
bench/spm_checker.sv
bench/tb_sparse_polynomial_add_merge.sv
